FILE: sv/utd_pkg.sv
// shared types, constants and helpers for the utf-8 to utf-16 decoder
package utd_pkg;

  // result kinds
  typedef enum logic [1:0] {
    KIND_UNIT   = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_REJECT = 2'd2
  } kind_t;

  // byte classification bounds
  localparam logic [7:0] ASCII_LIMIT = 8'h80;
  localparam logic [7:0] LEAD2_MIN   = 8'hC2;
  localparam logic [7:0] LEAD2_MAX   = 8'hDF;
  localparam logic [7:0] LEAD3_MIN   = 8'hE0;
  localparam logic [7:0] LEAD3_MAX   = 8'hEF;
  localparam logic [7:0] LEAD4_MIN   = 8'hF0;
  localparam logic [7:0] LEAD4_MAX   = 8'hF4;

  // scalar bounds and surrogate constants
  localparam logic [20:0] SCALAR_MAX  = 21'h10FFFF;
  localparam logic [20:0] SURR_MIN    = 21'h00D800;
  localparam logic [20:0] SURR_MAX    = 21'h00DFFF;
  localparam logic [20:0] BMP_MAX     = 21'h00FFFF;
  localparam logic [20:0] PLANE1_BASE = 21'h010000;
  localparam logic [20:0] HIGH_BASE   = 21'h00D800;
  localparam logic [20:0] LOW_BASE    = 21'h00DC00;

  // per-string decoder state
  typedef struct packed {
    logic [20:0] partial;
    logic [1:0]  bexp;
    logic [1:0]  oclass;
    logic        rej;
  } dec_state_t;

  // one result
  typedef struct packed {
    logic [20:0] value;
    kind_t       kind;
  } res_t;

  // all results caused by one byte
  typedef struct packed {
    res_t [2:0]  ent;
    logic [1:0]  cnt;
  } res_grp_t;

  // smallest legal scalar for each overlong class
  function automatic logic [20:0] class_min(input logic [1:0] oc);
    logic [20:0] m;
    unique case (oc)
      2'd0: m = 21'h000000;
      2'd1: m = 21'h000080;
      2'd2: m = 21'h000800;
      default: m = 21'h010000;
    endcase
    return m;
  endfunction

endpackage

FILE: sv/utd_if.sv
// channel interfaces for bytes, results and configuration writes
interface utd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_string;
  modport source (output valid, output data_byte, output end_of_string, input ready);
  modport sink (input valid, input data_byte, input end_of_string, output ready);
endinterface

interface utd_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_value;
  logic [1:0]  item_kind;
  logic        last_of_run;
  modport source (output valid, output code_value, output item_kind, output last_of_run,
                  input ready);
  modport sink (input valid, input code_value, input item_kind, input last_of_run,
                output ready);
endinterface

interface utd_cfg_if;
  logic valid;
  logic ready;
  logic emit_utf16;
  modport source (output valid, output emit_utf16, input ready);
  modport sink (input valid, input emit_utf16, output ready);
endinterface

FILE: sv/utd_decode.sv
// combinational byte decoder: next string state and the results of one byte
module utd_decode
  import utd_pkg::*;
(
  input  dec_state_t st_i,
  input  logic [7:0] data_byte,
  input  logic       end_of_string,
  input  logic       emit_utf16,
  output dec_state_t st_o,
  output res_grp_t   grp_o
);

  dec_state_t  st;
  res_grp_t    grp;
  logic [20:0] s;
  logic [20:0] v;
  logic        emit;
  logic [1:0]  k;

  always_comb begin
    st   = st_i;
    grp  = '0;
    s    = '0;
    v    = '0;
    emit = 1'b0;
    k    = 2'd0;

    // lead or continuation byte
    if (!st.rej) begin
      if (st.bexp == 2'd0) begin
        if (data_byte < ASCII_LIMIT) begin
          s    = {13'd0, data_byte};
          emit = 1'b1;
        end else if (data_byte >= LEAD2_MIN && data_byte <= LEAD2_MAX) begin
          st.partial = {16'd0, data_byte[4:0]};
          st.bexp    = 2'd1;
          st.oclass  = 2'd1;
        end else if (data_byte >= LEAD3_MIN && data_byte <= LEAD3_MAX) begin
          st.partial = {17'd0, data_byte[3:0]};
          st.bexp    = 2'd2;
          st.oclass  = 2'd2;
        end else if (data_byte >= LEAD4_MIN && data_byte <= LEAD4_MAX) begin
          st.partial = {18'd0, data_byte[2:0]};
          st.bexp    = 2'd3;
          st.oclass  = 2'd3;
        end else begin
          st.rej = 1'b1;
        end
      end else if (data_byte[7:6] != 2'b10) begin
        st.rej = 1'b1;
      end else begin
        st.partial = {st.partial[14:0], data_byte[5:0]};
        st.bexp    = st.bexp - 2'd1;
        if (st.bexp == 2'd0) begin
          s = st.partial;
          if (s < class_min(st.oclass) || s > SCALAR_MAX ||
              (s >= SURR_MIN && s <= SURR_MAX)) begin
            st.rej = 1'b1;
          end else begin
            emit = 1'b1;
          end
          st.partial = '0;
          st.oclass  = 2'd0;
        end
      end
    end

    // scalar out, split into a surrogate pair when asked
    if (emit) begin
      if (emit_utf16 && s > BMP_MAX) begin
        v = s - PLANE1_BASE;
        grp.ent[0].value = HIGH_BASE + {11'd0, v[19:10]};
        grp.ent[0].kind  = KIND_UNIT;
        grp.ent[1].value = LOW_BASE + {11'd0, v[9:0]};
        grp.ent[1].kind  = KIND_UNIT;
        k = 2'd2;
      end else begin
        grp.ent[0].value = s;
        grp.ent[0].kind  = KIND_UNIT;
        k = 2'd1;
      end
    end

    // end of string marker and state clear
    if (end_of_string) begin
      if (st.bexp != 2'd0) begin
        st.rej = 1'b1;
      end
      grp.ent[k].value = '0;
      grp.ent[k].kind  = st.rej ? KIND_REJECT : KIND_ACCEPT;
      k  = k + 2'd1;
      st = '0;
    end

    grp.cnt = k;
  end

  assign st_o  = st;
  assign grp_o = grp;

endmodule

FILE: sv/utd_serial.sv
// result register: holds the results of one byte and hands them out one a cycle while the receiver is ready
module utd_serial
  import utd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  res_grp_t  grp_i,
  output logic      can_load,
  utd_out_if.source out_ch
);

  res_t [2:0] ent_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       pop;
  res_t       cur;

  assign pop      = (cnt_r != 2'd0) && out_ch.ready;
  assign can_load = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ch.ready);

  // index and remaining count
  always_comb begin
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    if (load) begin
      cnt_nxt = grp_i.cnt;
      idx_nxt = 2'd0;
    end else if (pop) begin
      cnt_nxt = cnt_r - 2'd1;
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      idx_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (load) begin
      ent_r <= grp_i.ent;
    end
  end

  // current result
  always_comb begin
    unique case (idx_r)
      2'd0: cur = ent_r[0];
      2'd1: cur = ent_r[1];
      default: cur = ent_r[2];
    endcase
  end

  assign out_ch.valid       = (cnt_r != 2'd0);
  assign out_ch.code_value  = cur.value;
  assign out_ch.item_kind   = cur.kind;
  assign out_ch.last_of_run = (cnt_r == 2'd1);

endmodule

FILE: sv/utf8_to_utf16_decoder.sv
// Validating UTF-8 decoder emitting UTF-16 code units or whole scalars.
// A byte's results are loaded into the result register as the byte is accepted; the first is offered in the next cycle.
// Throughput: one byte a cycle while each byte gives at most one result and the receiver is
// ready; a byte with more results holds the input until its last is taken (single result register).
// Reset: string state cleared, result register empty, emit_utf16 set to 1.
module utf8_to_utf16_decoder
  import utd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  utd_in_if.sink    in_ch,
  utd_out_if.source out_ch,
  utd_cfg_if.sink   cfg_ch
);

  dec_state_t st_r, st_nxt;
  res_grp_t   grp;
  logic       emit_r;
  logic       can_load;
  logic       in_acc;

  assign in_ch.ready  = can_load;
  assign in_acc       = in_ch.valid && can_load;
  assign cfg_ch.ready = 1'b1;

  // per-byte decode
  utd_decode u_decode (
    .st_i          (st_r),
    .data_byte     (in_ch.data_byte),
    .end_of_string (in_ch.end_of_string),
    .emit_utf16    (emit_r),
    .st_o          (st_nxt),
    .grp_o         (grp)
  );

  // string state and configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= '0;
      emit_r <= 1'b1;
    end else begin
      if (in_acc) begin
        st_r <= st_nxt;
      end
      if (cfg_ch.valid) begin
        emit_r <= cfg_ch.emit_utf16;
      end
    end
  end

  // result register and output sequencing
  utd_serial u_serial (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (in_acc),
    .grp_i    (grp),
    .can_load (can_load),
    .out_ch   (out_ch)
  );

endmodule

FILE: dv/tb_top.sv
// testbench for the utf-8 decoder: random and directed strings checked against a byte predictor
`timescale 1ns / 100ps

module tb_top
  import utd_pkg::*;
();

  localparam int          CYCLE_LIMIT = 300000;
  localparam int          LONG_HOLD   = 150;
  localparam int          SETTLE      = 4;
  localparam int          PRINT_CAP   = 40;
  localparam logic [1:0]  CONT_TAG    = 2'b10;

  typedef struct packed {
    logic [7:0] data;
    logic       eos;
  } byte_item_t;

  typedef struct {
    logic [20:0] value;
    kind_t       kind;
    logic        last;
  } unit_due_t;

  typedef enum int {
    FAULT_NONE, FAULT_BAD_LEAD, FAULT_NO_CONT, FAULT_OVERLONG,
    FAULT_TOO_BIG, FAULT_SURROGATE, FAULT_TRUNC, FAULT_NOISE
  } fault_t;

  logic clk = 1'b0;
  logic rst_n;

  utd_in_if  in_if ();
  utd_out_if out_if ();
  utd_cfg_if cfg_if ();

  utf8_to_utf16_decoder u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always #6 clk = ~clk;

  // stimulus and expectation stores
  byte_item_t bytes_to_send[$];
  logic [7:0] str_bytes[$];
  unit_due_t  units_due[$];

  // flow control knobs, changed by the sequence on falling edges
  int src_idle_pct  = 0;
  int snk_stall_pct = 0;
  bit src_hold      = 1'b0;
  int hold_asks     = 0;
  int hold_taken;
  int hold_left;

  // run statistics
  int cycle_cnt     = 0;
  int err_count     = 0;
  int bytes_sent    = 0;
  int units_seen    = 0;
  int accepts_seen  = 0;
  int rejects_seen  = 0;
  int strings_built = 0;
  bit mode0_used    = 1'b0;

  // predictor state: mirrors one string in progress
  logic        utf16_mode = 1'b1;
  logic [20:0] str_acc    = '0;
  logic [1:0]  str_need   = '0;
  logic [20:0] str_floor  = '0;
  logic        str_rej    = 1'b0;

  function automatic void expect_unit(input logic [20:0] value, input kind_t kind);
    unit_due_t u;
    u.value = value;
    u.kind  = kind;
    u.last  = 1'b0;
    units_due.push_back(u);
  endfunction

  // a finished scalar, split into a surrogate pair when utf-16 output is on
  function automatic void expect_scalar(input logic [20:0] sc);
    logic [20:0] off;
    if (utf16_mode && sc > BMP_MAX) begin
      off = sc - PLANE1_BASE;
      expect_unit(HIGH_BASE + {11'd0, off[19:10]}, KIND_UNIT);
      expect_unit(LOW_BASE + {11'd0, off[9:0]}, KIND_UNIT);
    end else begin
      expect_unit(sc, KIND_UNIT);
    end
  endfunction

  // predicted code units for one accepted byte
  function automatic void decode_utf8_byte(input logic [7:0] b, input logic eos);
    int          n0;
    logic [20:0] sc;
    n0 = units_due.size();
    if (!str_rej) begin
      if (str_need == 2'd0) begin
        if (b < ASCII_LIMIT) begin
          expect_scalar({13'd0, b});
        end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
          str_acc = {16'd0, b[4:0]}; str_need = 2'd1; str_floor = 21'h80;
        end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
          str_acc = {17'd0, b[3:0]}; str_need = 2'd2; str_floor = 21'h800;
        end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
          str_acc = {18'd0, b[2:0]}; str_need = 2'd3; str_floor = PLANE1_BASE;
        end else begin
          str_rej = 1'b1;
        end
      end else if (b[7:6] != CONT_TAG) begin
        str_rej = 1'b1;
      end else begin
        str_acc  = {str_acc[14:0], b[5:0]};
        str_need = str_need - 2'd1;
        if (str_need == 2'd0) begin
          sc = str_acc;
          if (sc < str_floor || sc > SCALAR_MAX || (sc >= SURR_MIN && sc <= SURR_MAX))
            str_rej = 1'b1;
          else
            expect_scalar(sc);
          str_acc   = '0;
          str_floor = '0;
        end
      end
    end
    // end of string: truncation check, then the marker
    if (eos) begin
      if (str_need != 2'd0) str_rej = 1'b1;
      expect_unit(21'd0, str_rej ? KIND_REJECT : KIND_ACCEPT);
      str_acc   = '0;
      str_need  = '0;
      str_floor = '0;
      str_rej   = 1'b0;
    end
    if (units_due.size() > n0) units_due[units_due.size() - 1].last = 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [20:0] got,
                                 input logic [20:0] want);
    err_count++;
    if (err_count <= PRINT_CAP)
      $display("mismatch on %s at cycle %0d: got %0h, wanted %0h", what, cycle_cnt, got, want);
  endtask

  task automatic check_unit();
    unit_due_t want;
    if (units_due.size() == 0) begin
      report_mismatch("unexpected result", out_if.code_value, 21'd0);
    end else begin
      want = units_due.pop_front();
      if (out_if.code_value !== want.value)
        report_mismatch("code_value", out_if.code_value, want.value);
      if (out_if.item_kind !== want.kind)
        report_mismatch("item_kind", {19'd0, out_if.item_kind}, {19'd0, want.kind});
      if (out_if.last_of_run !== want.last)
        report_mismatch("last_of_run", {20'd0, out_if.last_of_run}, {20'd0, want.last});
    end
    if (out_if.item_kind == KIND_ACCEPT) accepts_seen++;
    else if (out_if.item_kind == KIND_REJECT) rejects_seen++;
    else units_seen++;
  endtask

  // byte driver: holds an offered transaction until it is taken
  always @(posedge clk) begin : drive_bytes
    logic offer;
    offer = 1'b0;
    if (!rst_n) begin
      in_if.valid         <= 1'b0;
      in_if.data_byte     <= 8'h00;
      in_if.end_of_string <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        decode_utf8_byte(bytes_to_send[0].data, bytes_to_send[0].eos);
        void'(bytes_to_send.pop_front());
        bytes_sent++;
      end
      if (in_if.valid && !in_if.ready)
        offer = 1'b1;
      else if (bytes_to_send.size() != 0 && !src_hold && $urandom_range(99) >= src_idle_pct)
        offer = 1'b1;
      in_if.valid <= offer;
      if (offer) begin
        in_if.data_byte     <= bytes_to_send[0].data;
        in_if.end_of_string <= bytes_to_send[0].eos;
      end
    end
  end

  // result monitor and random back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) check_unit();
      out_if.ready <= (hold_left == 0) && ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left  <= 0;
      hold_taken <= 0;
    end else if (hold_asks != hold_taken) begin
      hold_left  <= LONG_HOLD;
      hold_taken <= hold_asks;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // utf-8 encoding of a scalar at a given length, keeping the first bytes only
  task automatic add_encoded(input logic [20:0] s, input int len, input int keep);
    logic [7:0] enc [4];
    case (len)
      1: enc[0] = {1'b0, s[6:0]};
      2: begin
        enc[0] = {3'b110, s[10:6]};
        enc[1] = {CONT_TAG, s[5:0]};
      end
      3: begin
        enc[0] = {4'b1110, s[15:12]};
        enc[1] = {CONT_TAG, s[11:6]};
        enc[2] = {CONT_TAG, s[5:0]};
      end
      default: begin
        enc[0] = {5'b11110, s[20:18]};
        enc[1] = {CONT_TAG, s[17:12]};
        enc[2] = {CONT_TAG, s[11:6]};
        enc[3] = {CONT_TAG, s[5:0]};
      end
    endcase
    for (int i = 0; i < keep; i++) str_bytes.push_back(enc[i]);
  endtask

  function automatic logic [20:0] random_scalar(input int len);
    logic [20:0] s;
    case (len)
      1: s = 21'($urandom_range(0, 'h7F));
      2: s = 21'($urandom_range('h80, 'h7FF));
      3: begin
        s = 21'($urandom_range('h800, 'hFFFF));
        if (s >= SURR_MIN && s <= SURR_MAX) s = s ^ 21'h2000;
      end
      default: s = 21'($urandom_range(PLANE1_BASE, SCALAR_MAX));
    endcase
    return s;
  endfunction

  // queue the staged string, end flag on its last byte
  task automatic send_string();
    byte_item_t it;
    foreach (str_bytes[i]) begin
      it.data = str_bytes[i];
      it.eos  = (i == str_bytes.size() - 1);
      bytes_to_send.push_back(it);
    end
    strings_built++;
    str_bytes.delete();
  endtask

  // one random string, mostly well formed, sometimes with a single fault
  task automatic build_string();
    int          n_sc;
    int          bad_at;
    int          len;
    bit          cut;
    fault_t      fault;
    logic [7:0]  b;
    logic [20:0] s;
    n_sc   = $urandom_range(1, 5);
    bad_at = $urandom_range(0, n_sc - 1);
    fault  = ($urandom_range(99) < 30) ? fault_t'($urandom_range(FAULT_BAD_LEAD, FAULT_NOISE))
                                       : FAULT_NONE;
    cut    = 1'b0;
    for (int i = 0; i < n_sc && !cut; i++) begin
      if (i != bad_at || fault == FAULT_NONE) begin
        len = $urandom_range(1, 4);
        add_encoded(random_scalar(len), len, len);
      end else begin
        case (fault)
          FAULT_BAD_LEAD: begin
            if ($urandom_range(1))
              b = 8'($urandom_range(ASCII_LIMIT, LEAD2_MIN - 1));
            else
              b = 8'($urandom_range(LEAD4_MAX + 1, 'hFF));
            str_bytes.push_back(b);
          end
          FAULT_NO_CONT: begin
            len = $urandom_range(2, 4);
            add_encoded(random_scalar(len), len, $urandom_range(1, len - 1));
            b = 8'($urandom_range(0, 255));
            if (b[7:6] == CONT_TAG) b[6] = 1'b1;
            str_bytes.push_back(b);
          end
          FAULT_OVERLONG: begin
            len = $urandom_range(2, 4);
            s = 21'($urandom_range(0, (len == 2) ? 'h7F : (len == 3) ? 'h7FF : 'hFFFF));
            add_encoded(s, len, len);
          end
          FAULT_TOO_BIG: begin
            s = 21'($urandom_range(SCALAR_MAX + 1, 'h1FFFFF));
            add_encoded(s, 4, 4);
          end
          FAULT_SURROGATE: begin
            s = 21'($urandom_range(SURR_MIN, SURR_MAX));
            add_encoded(s, 3, 3);
          end
          FAULT_TRUNC: begin
            len = $urandom_range(2, 4);
            add_encoded(random_scalar(len), len, $urandom_range(1, len - 1));
            cut = 1'b1;
          end
          default: begin
            repeat ($urandom_range(1, 6)) str_bytes.push_back(8'($urandom_range(0, 255)));
          end
        endcase
      end
    end
    send_string();
  endtask

  task automatic wait_drained();
    while (bytes_to_send.size() != 0 || in_if.valid || units_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_mode(input logic mode);
    @(posedge clk);
    cfg_if.valid      <= 1'b1;
    cfg_if.emit_utf16 <= mode;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    utf16_mode = mode;
    if (!mode) mode0_used = 1'b1;
    @(negedge clk);
  endtask

  task automatic run_random(input int budget, input int idle_pct, input int stall_pct);
    int queued;
    @(negedge clk);
    src_idle_pct  = idle_pct;
    snk_stall_pct = stall_pct;
    queued = bytes_to_send.size();
    while (bytes_to_send.size() - queued < budget) build_string();
    wait_drained();
  endtask

  // sequence of phases
  initial begin
    cfg_if.valid        = 1'b0;
    cfg_if.emit_utf16   = 1'b1;
    rst_n               = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed strings, reset mode (utf-16 output)
    str_bytes = '{8'h00, 8'h7F};             send_string();
    str_bytes = '{8'hC2, 8'h80};             send_string();
    str_bytes = '{8'hF4, 8'h8F, 8'hBF, 8'hBF}; send_string();
    str_bytes = '{8'hFF};                    send_string();
    str_bytes = '{8'hE0, 8'h80, 8'h80};       send_string();
    str_bytes = '{8'hF4, 8'h90, 8'h80, 8'h80}; send_string();
    str_bytes = '{8'hED, 8'hA0, 8'h80};       send_string();
    str_bytes = '{8'hC3};                    send_string();
    // unit kept, then missing continuation and ignored tail
    str_bytes = '{8'h41, 8'hC3, 8'h41, 8'h42}; send_string();
    wait_drained();

    // whole scalars, no idling
    write_mode(1'b0);
    run_random(60, 0, 0);

    // mode switched while a four-byte sequence is open
    str_bytes = '{8'hF0, 8'h9F, 8'h98};
    foreach (str_bytes[i]) bytes_to_send.push_back('{data: str_bytes[i], eos: 1'b0});
    str_bytes.delete();
    wait_drained();
    write_mode(1'b1);
    bytes_to_send.push_back('{data: 8'h80, eos: 1'b1});
    wait_drained();

    run_random(60, 77, 0);
    write_mode(1'b0);
    run_random(60, 0, 77);
    write_mode(1'b1);
    run_random(60, 7, 7);

    // long receiver hold-off, then a sender pause until all results are in
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    hold_asks     = hold_asks + 1;
    while (bytes_to_send.size() < 50) build_string();
    while (bytes_to_send.size() > 20) @(negedge clk);
    src_hold = 1'b1;
    while (in_if.valid || units_due.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    src_hold = 1'b0;
    wait_drained();

    repeat (8) @(posedge clk);
    if (units_due.size() != 0)
      report_mismatch("results still outstanding", 21'(units_due.size()), 21'd0);
    $display("run covered %0d bytes in %0d strings, %0d code units checked",
             bytes_sent, strings_built, units_seen);
    $display("%0d strings accepted, %0d rejected, whole-scalar mode used: %0d",
             accepts_seen, rejects_seen, mode0_used);
    if (err_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

FILE: filelist.f
sv/utd_pkg.sv
sv/utd_if.sv
sv/utd_decode.sv
sv/utd_serial.sv
sv/utf8_to_utf16_decoder.sv
dv/tb_top.sv
